>>> design/vrr_pkg.sv
// Package for the refract/reflect unit: constants, stage payload type and rounding helpers.
`default_nettype none

package vrr_pkg;

  // Fixed-point format of all vectors and index ratios.
  localparam int FRAC_BITS = 14;

  // Working width of the rounding and saturation helpers.
  localparam int WORK_W = 48;

  // 1.0 in the format of a product of two fixed-point values.
  localparam logic signed [WORK_W-1:0] ONE2 = WORK_W'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [WORK_W-1:0] RND_HALF = WORK_W'(1) <<< (FRAC_BITS - 1);

  // Register reset values.
  localparam logic [15:0] ETA_ABOVE_RST = 16'd12307;
  localparam logic [15:0] ETA_BELOW_RST = 16'd21810;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    CFG_ETA_ABOVE = 1'b0,
    CFG_ETA_BELOW = 1'b1
  } cfg_idx_e;

  // Square root unit geometry.
  localparam int K_W         = 42;
  localparam int ROOT_W      = K_W / 2;
  localparam int REM_W       = ROOT_W + 4;
  localparam int SQRT_STEPS  = 3;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // Values that ride along with an item through the square root stages.
  typedef struct packed {
    logic [2:0][15:0] v;    // incident direction
    logic [2:0][16:0] ns;   // normal, flipped to the incident side
    logic [15:0]      e;    // selected index ratio
    logic [19:0]      ecr;  // round(eta * cos)
    logic [2:0][15:0] mir;  // saturated mirror vector
    logic             tir;  // total internal reflection
  } side_t;

  // Reduce a double-width product by FRAC_BITS, rounding half up.
  function automatic logic signed [WORK_W-1:0] rnd_q(input logic signed [WORK_W-1:0] x);
    rnd_q = (x + RND_HALF) >>> FRAC_BITS;
  endfunction

  // Saturate to the signed 16-bit range.
  function automatic logic [15:0] sat16(input logic signed [WORK_W-1:0] x);
    logic [15:0] r;
    if (x > WORK_W'(32767)) begin
      r = 16'h7fff;
    end else if (x < -WORK_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/vrr_if.sv
// Item channel interfaces of the refract/reflect unit.
`default_nettype none

interface vrr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, output ready);
endinterface

interface vrr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               total_reflect;

  modport source (output valid, out_x, out_y, out_z, total_reflect, input ready);
  modport sink (input valid, out_x, out_y, out_z, total_reflect, output ready);
endinterface

`default_nettype wire

>>> design/vrr_isqrt.sv
// Pipelined integer square root with a side payload, three result bits per stage.
`default_nettype none

module vrr_isqrt
  import vrr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [K_W-1:0]    k_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);

  logic [SQRT_STAGES-1:0] vld_q;
  logic [REM_W-1:0]       rem_q  [SQRT_STAGES];
  logic [REM_W-1:0]       rem_d  [SQRT_STAGES];
  logic [ROOT_W-1:0]      root_q [SQRT_STAGES];
  logic [ROOT_W-1:0]      root_d [SQRT_STAGES];
  logic [K_W-1:0]         kr_q   [SQRT_STAGES];
  logic [K_W-1:0]         kr_d   [SQRT_STAGES];
  side_t                  side_q [SQRT_STAGES];

  // Restoring digit recurrence: bring down two radicand bits, try 4*root+1.
  always_comb begin
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [K_W-1:0]    kr;
    logic [REM_W-1:0]  trial;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        rem  = '0;
        root = '0;
        kr   = k_i;
      end else begin
        rem  = rem_q[s-1];
        root = root_q[s-1];
        kr   = kr_q[s-1];
      end
      for (int j = 0; j < SQRT_STEPS; j++) begin
        rem   = {rem[REM_W-3:0], kr[K_W-1:K_W-2]};
        kr    = {kr[K_W-3:0], 2'b00};
        trial = {2'b00, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[ROOT_W-2:0], 1'b1};
        end else begin
          root = {root[ROOT_W-2:0], 1'b0};
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
      kr_d[s]   = kr;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SQRT_STAGES-2:0], vld_i};
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 0; s < SQRT_STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        kr_q[s]   <= kr_d[s];
      end
      for (int s = 1; s < SQRT_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign vld_o  = vld_q[SQRT_STAGES-1];
  assign root_o = root_q[SQRT_STAGES-1];
  assign side_o = side_q[SQRT_STAGES-1];

  // The final remainder never exceeds twice the root.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> rem_q[SQRT_STAGES-1] <= {root_o, 1'b0})
    else $error("square root remainder out of range");

  // A stall freezes every stage.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(vld_q))
    else $error("square root stage moved during stall");

endmodule

`default_nettype wire

>>> design/vector_refract_reflect_unit_top.sv
// Top level of the refract/reflect unit: pipeline from vector pair to refracted or mirrored direction.
//
//   channel  direction  payload                                   handshake
//   in_i     sink       dir_x/y/z, norm_x/y/z (signed Q2.14)      valid/ready
//   out_o    source     out_x/y/z (signed Q2.14), total_reflect   valid/ready
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_wdata_i          write enable only
//
// One item is taken per cycle while the output register is not stalled.
// Six arithmetic stages, seven square root stages (three root bits each), a product
// stage and the output register; the 21-bit square root sets the depth.
// Reset clears all valid bits and loads the index ratios with their defaults.
// A stall at the output freezes the whole pipe in place; ready is low only while the
// output register holds an item that is not taken.
`default_nettype none

module vector_refract_reflect_unit_top
  import vrr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  vrr_in_if.sink           in_i,
  vrr_out_if.source        out_o
);

  logic en;

  // Configuration registers.
  logic [15:0] eta_above_q;
  logic [15:0] eta_below_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_above_q <= ETA_ABOVE_RST;
      eta_below_q <= ETA_BELOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ETA_ABOVE: eta_above_q <= cfg_wdata_i;
        CFG_ETA_BELOW: eta_below_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipe advances unless the output holds an untaken item.
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;

  // Stage 1: all nine component products.
  logic signed [15:0] v1_q [3];
  logic signed [15:0] n1_q [3];
  logic signed [31:0] p1_q [3][3];   // [normal][direction]

  always_ff @(posedge clk_i) begin
    logic signed [15:0] vi [3];
    logic signed [15:0] ni [3];
    vi = '{in_i.dir_x, in_i.dir_y, in_i.dir_z};
    ni = '{in_i.norm_x, in_i.norm_y, in_i.norm_z};
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        v1_q[a] <= vi[a];
        n1_q[a] <= ni[a];
        for (int b = 0; b < 3; b++) begin
          p1_q[a][b] <= 32'(ni[a]) * 32'(vi[b]);
        end
      end
    end
  end

  // Stage 2: cross product, side selection and cosine.
  logic signed [15:0] v2_q  [3];
  logic signed [16:0] ns2_q [3];
  logic signed [18:0] cx2_q [3];
  logic [17:0]        c2_q;
  logic [15:0]        e2_q;

  always_ff @(posedge clk_i) begin
    logic signed [WORK_W-1:0] dx [3];
    logic signed [WORK_W-1:0] dot;
    logic signed [WORK_W-1:0] r;
    logic                     neg;
    dx[0] = WORK_W'(p1_q[1][2]) - WORK_W'(p1_q[2][1]);
    dx[1] = WORK_W'(p1_q[2][0]) - WORK_W'(p1_q[0][2]);
    dx[2] = WORK_W'(p1_q[0][1]) - WORK_W'(p1_q[1][0]);
    dot = WORK_W'(p1_q[0][0]) + WORK_W'(p1_q[1][1]) + WORK_W'(p1_q[2][2]);
    neg = dot < 0;
    r   = rnd_q(neg ? -dot : dot);
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [WORK_W-1:0] cr;
        cr = rnd_q(dx[a]);
        v2_q[a]  <= v1_q[a];
        ns2_q[a] <= neg ? -17'(n1_q[a]) : 17'(n1_q[a]);
        cx2_q[a] <= cr[18:0];
      end
      c2_q <= r[17:0];
      e2_q <= neg ? eta_below_q : eta_above_q;
    end
  end

  // Stage 3: squares and products with the cosine and the ratio.
  logic signed [15:0] v3_q  [3];
  logic signed [16:0] ns3_q [3];
  logic [35:0]        sq3_q [3];
  logic signed [35:0] cn3_q [3];
  logic [35:0]        cc3_q;
  logic [31:0]        ee3_q;
  logic [33:0]        ec3_q;
  logic [15:0]        e3_q;

  always_ff @(posedge clk_i) begin
    logic signed [37:0] sq;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq = 38'(cx2_q[a]) * 38'(cx2_q[a]);
        v3_q[a]  <= v2_q[a];
        ns3_q[a] <= ns2_q[a];
        sq3_q[a] <= sq[35:0];
        cn3_q[a] <= 36'($signed({1'b0, c2_q})) * 36'(ns2_q[a]);
      end
      cc3_q <= 36'(c2_q) * 36'(c2_q);
      ee3_q <= 32'(e2_q) * 32'(e2_q);
      ec3_q <= 34'(e2_q) * 34'(c2_q);
      e3_q  <= e2_q;
    end
  end

  // Stage 4: rounding to Q2.14 and the mirror vector.
  logic signed [15:0] v4_q  [3];
  logic signed [16:0] ns4_q [3];
  logic [15:0]        mir4_q [3];
  logic [21:0]        sin2_4_q;
  logic [18:0]        eta2_4_q;
  logic signed [22:0] om4_q;
  logic [19:0]        ecr4_q;
  logic [15:0]        e4_q;

  always_ff @(posedge clk_i) begin
    logic signed [WORK_W-1:0] s2;
    logic signed [WORK_W-1:0] et;
    logic signed [WORK_W-1:0] om;
    logic signed [WORK_W-1:0] ecr;
    logic signed [WORK_W-1:0] mr;
    s2  = rnd_q($signed(WORK_W'(sq3_q[0])) + $signed(WORK_W'(sq3_q[1]))
                + $signed(WORK_W'(sq3_q[2])));
    et  = rnd_q($signed(WORK_W'(ee3_q)));
    om  = rnd_q(ONE2 - $signed(WORK_W'(cc3_q)));
    ecr = rnd_q($signed(WORK_W'(ec3_q)));
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        mr = rnd_q(WORK_W'(cn3_q[a]) <<< 1) - WORK_W'(v3_q[a]);
        v4_q[a]   <= v3_q[a];
        ns4_q[a]  <= ns3_q[a];
        mir4_q[a] <= sat16(mr);
      end
      sin2_4_q <= s2[21:0];
      eta2_4_q <= et[18:0];
      om4_q    <= om[22:0];
      ecr4_q   <= ecr[19:0];
      e4_q     <= e3_q;
    end
  end

  // Stage 5: reflection test product and radicand product.
  logic [40:0]        t5_q;
  logic signed [42:0] eo5_q;
  side_t              side5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_q  <= 41'(sin2_4_q) * 41'(eta2_4_q);
      eo5_q <= 43'($signed({1'b0, eta2_4_q})) * 43'(om4_q);
      for (int a = 0; a < 3; a++) begin
        side5_q.v[a]   <= v4_q[a];
        side5_q.ns[a]  <= ns4_q[a];
        side5_q.mir[a] <= mir4_q[a];
      end
      side5_q.e   <= e4_q;
      side5_q.ecr <= ecr4_q;
      side5_q.tir <= 1'b0;
    end
  end

  // Stage 6: total reflection decision and clamped radicand.
  logic [K_W-1:0] k6_q;
  side_t          side6_q;

  always_ff @(posedge clk_i) begin
    logic signed [WORK_W-1:0] k;
    side_t                    sd;
    k      = ONE2 - WORK_W'(eo5_q);
    sd     = side5_q;
    sd.tir = $signed(WORK_W'(t5_q)) >= ONE2;
    if (en) begin
      k6_q    <= (k > 0) ? k[K_W-1:0] : '0;
      side6_q <= sd;
    end
  end

  // Square root of the radicand.
  logic              vld_s;
  logic [ROOT_W-1:0] root_s;
  side_t             side_s;

  vrr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld6_q),
    .k_i    (k6_q),
    .side_i (side6_q),
    .vld_o  (vld_s),
    .root_o (root_s),
    .side_o (side_s)
  );

  // Stage 7: refraction products.
  logic signed [32:0] ev7_q  [3];
  logic signed [39:0] cnn7_q [3];
  logic [15:0]        mir7_q [3];
  logic               tir7_q;

  always_ff @(posedge clk_i) begin
    logic signed [22:0] coef;
    coef = $signed({3'b000, side_s.ecr}) - $signed({2'b00, root_s});
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        ev7_q[a]  <= 33'($signed({1'b0, side_s.e})) * 33'($signed(side_s.v[a]));
        cnn7_q[a] <= 40'(coef) * 40'($signed(side_s.ns[a]));
        mir7_q[a] <= side_s.mir[a];
      end
      tir7_q <= side_s.tir;
    end
  end

  // Output register: combine, round, saturate and pick the result.
  logic [15:0] out_q [3];
  logic        tir_q;

  always_ff @(posedge clk_i) begin
    logic signed [WORK_W-1:0] s;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s = rnd_q(WORK_W'(cnn7_q[a]) - WORK_W'(ev7_q[a]));
        out_q[a] <= tir7_q ? mir7_q[a] : sat16(s);
      end
      tir_q <= tir7_q;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      vld7_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= in_i.valid;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      vld5_q    <= vld4_q;
      vld6_q    <= vld5_q;
      vld7_q    <= vld_s;
      out_vld_q <= vld7_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.out_x         = $signed(out_q[0]);
  assign out_o.out_y         = $signed(out_q[1]);
  assign out_o.out_z         = $signed(out_q[2]);
  assign out_o.total_reflect = tir_q;

  // One minus cos squared can never exceed one.
  a_om_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q |-> om4_q <= 23'sd16384)
    else $error("one minus cos squared above one");

  // A zero ratio never reports total reflection.
  a_zero_eta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld6_q && side6_q.e == 16'd0 |-> !side6_q.tir)
    else $error("total reflection with zero index ratio");

  // A stall freezes the valid bits of stages one to seven.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q}))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
